>>> rtl/smou_pkg.sv
// Shared types, constants and helpers for the sign-momentum optimizer update block.
package smou_pkg;

   localparam int DataW   = 32;
   localparam int LrW     = 32;
   localparam int BlendW  = 17;
   localparam int DecayW  = 20;
   localparam int LwW     = LrW + DecayW;
   localparam int LwHalfW = LwW / 2;
   localparam int AddrW   = 4;
   localparam int CsrW    = 32;
   localparam int ProdW   = DataW + BlendW + 1;
   localparam int SumW    = ProdW + 1;
   localparam int DecProdW = DataW + LwHalfW + 1;
   localparam int DecSumW = DecProdW + LwHalfW;
   localparam int DecayOutW = DecSumW - 2 * LwHalfW + 4;
   localparam int StepW   = LrW - 8 + 2;
   localparam int WideW   = 40;

   localparam logic [BlendW-1:0] BlendOne = 17'd65536;

   localparam logic [LrW-1:0]    LrReset    = 32'd429497;
   localparam logic [BlendW-1:0] Beta1Reset = 17'd58982;
   localparam logic [BlendW-1:0] Beta2Reset = 17'd64881;
   localparam logic [DecayW-1:0] DecayReset = 20'd0;

   typedef enum logic [1:0] {
      REG_LR    = 2'd0,
      REG_BETA1 = 2'd1,
      REG_BETA2 = 2'd2,
      REG_DECAY = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [LrW-1:0]    lr;
      logic [BlendW-1:0] b1;
      logic [BlendW-1:0] b1c;
      logic [BlendW-1:0] b2;
      logic [BlendW-1:0] b2c;
      logic [LwW-1:0]    lw;
   } cfg_type;

   typedef struct packed {
      logic                    clip;
      logic signed [DataW-1:0] value;
   } sat_type;

   function automatic sat_type sat_to_data(input logic signed [WideW-1:0] v);
      sat_type r;
      if (v > WideW'(signed'(33'sh0_7FFF_FFFF))) begin
         r.clip  = 1'b1;
         r.value = 32'sh7FFF_FFFF;
      end else if (v < WideW'(signed'(33'sh1_8000_0000))) begin
         r.clip  = 1'b1;
         r.value = 32'sh8000_0000;
      end else begin
         r.clip  = 1'b0;
         r.value = v[DataW-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/smou_chan_if.sv
// Valid/ready channel interfaces for request and response beats.
interface smou_req_if;
   import smou_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] param_in;
   logic signed [DataW-1:0] momentum_in;
   logic signed [DataW-1:0] gradient;

   modport source(output valid, param_in, momentum_in, gradient, input ready);
   modport sink(input valid, param_in, momentum_in, gradient, output ready);
endinterface

interface smou_rsp_if;
   import smou_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] param_out;
   logic signed [DataW-1:0] momentum_out;
   logic                    saturated;

   modport source(output valid, param_out, momentum_out, saturated, input ready);
   modport sink(input valid, param_out, momentum_out, saturated, output ready);
endinterface

>>> rtl/smou_csr.sv
// APB register file holding learning rate, blend weights and decay.
module smou_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [smou_pkg::AddrW-1:0]   paddr,
   input  logic [smou_pkg::CsrW-1:0]    pwdata,
   output logic [smou_pkg::CsrW-1:0]    prdata,
   output logic                         pready,
   output smou_pkg::cfg_type            cfg
);
   import smou_pkg::*;

   logic [LrW-1:0]    lr_ff;
   logic [BlendW-1:0] b1_ff;
   logic [BlendW-1:0] b2_ff;
   logic [DecayW-1:0] wd_ff;
   logic [LwW-1:0]    lw_ff;
   logic [LwW-1:0]    lw_in;
   logic [BlendW-1:0] b1_clamp;
   logic [BlendW-1:0] b2_clamp;
   logic              wr_en;
   reg_idx_type       idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_idx_type'(paddr[AddrW-1:2]);
   assign lw_in  = LwW'(lr_ff) * LwW'(wd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= LrReset;
         b1_ff <= Beta1Reset;
         b2_ff <= Beta2Reset;
         wd_ff <= DecayReset;
         lw_ff <= '0;
      end else begin
         lw_ff <= lw_in;
         if (wr_en) begin
            case (idx)
               REG_LR:    lr_ff <= pwdata[LrW-1:0];
               REG_BETA1: b1_ff <= pwdata[BlendW-1:0];
               REG_BETA2: b2_ff <= pwdata[BlendW-1:0];
               REG_DECAY: wd_ff <= pwdata[DecayW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (idx)
         REG_LR:    prdata = lr_ff;
         REG_BETA1: prdata = CsrW'(b1_ff);
         REG_BETA2: prdata = CsrW'(b2_ff);
         REG_DECAY: prdata = CsrW'(wd_ff);
         default:   prdata = '0;
      endcase
   end

   // weights above one act as one
   assign b1_clamp = (b1_ff > BlendOne) ? BlendOne : b1_ff;
   assign b2_clamp = (b2_ff > BlendOne) ? BlendOne : b2_ff;

   assign cfg.lr  = lr_ff;
   assign cfg.b1  = b1_clamp;
   assign cfg.b1c = BlendOne - b1_clamp;
   assign cfg.b2  = b2_clamp;
   assign cfg.b2c = BlendOne - b2_clamp;
   assign cfg.lw  = lw_ff;
endmodule

>>> rtl/smou_pipe.sv
// Four-stage update pipeline: input, products, sums, parameter subtract.
module smou_pipe (
   input  logic              clock,
   input  logic              reset,
   input  smou_pkg::cfg_type cfg,
   smou_req_if.sink          req_chan,
   smou_rsp_if.source        rsp_chan
);
   import smou_pkg::*;

   logic en1, en2, en3, en4;

   // stage 1: input beat
   logic                    v1_ff;
   logic signed [DataW-1:0] p1_ff, m1_ff, g1_ff;

   // stage 2: products
   logic                       v2_ff;
   logic signed [DataW-1:0]    p2_ff;
   logic signed [ProdW-1:0]    sb_m_ff, sb_g_ff, mb_m_ff, mb_g_ff;
   logic signed [ProdW-1:0]    sb_m_in, sb_g_in, mb_m_in, mb_g_in;
   logic signed [DecProdW-1:0] dec_hi_ff, dec_lo_ff, dec_hi_in, dec_lo_in;

   // stage 3: sums
   logic                        v3_ff;
   logic signed [DataW-1:0]     p3_ff;
   logic signed [StepW-1:0]     step_ff, step_in;
   logic signed [DecayOutW-1:0] decay_ff, decay_in;
   logic signed [DataW-1:0]     mom_ff;
   logic                        msat_ff;
   logic [SumW-1:0]             sb_sum, mb_sum;
   logic [DecSumW:0]            dec_sum;
   logic [LrW+1:0]              lr_neg;
   sat_type                     mom_sat;

   // stage 4: output beat
   logic                    v4_ff;
   logic signed [DataW-1:0] po_ff, mo_ff;
   logic                    so_ff;
   logic signed [WideW-1:0] newp;
   sat_type                 par_sat;

   assign en4 = !v4_ff || rsp_chan.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   assign sb_m_in   = m1_ff * $signed({1'b0, cfg.b1});
   assign sb_g_in   = g1_ff * $signed({1'b0, cfg.b1c});
   assign mb_m_in   = m1_ff * $signed({1'b0, cfg.b2});
   assign mb_g_in   = g1_ff * $signed({1'b0, cfg.b2c});
   assign dec_hi_in = p1_ff * $signed({1'b0, cfg.lw[LwW-1:LwHalfW]});
   assign dec_lo_in = p1_ff * $signed({1'b0, cfg.lw[LwHalfW-1:0]});

   assign sb_sum  = {sb_m_ff[ProdW-1], sb_m_ff} + {sb_g_ff[ProdW-1], sb_g_ff};
   assign mb_sum  = {mb_m_ff[ProdW-1], mb_m_ff} + {mb_g_ff[ProdW-1], mb_g_ff};
   assign dec_sum = {dec_hi_ff[DecProdW-1], dec_hi_ff, {LwHalfW{1'b0}}}
                  + {{(LwHalfW+1){dec_lo_ff[DecProdW-1]}}, dec_lo_ff};
   // floor of the exact decay product over 2^48
   assign decay_in = dec_sum[48 +: DecayOutW];
   assign mom_sat  = sat_to_data(WideW'($signed(mb_sum[SumW-1:16])));
   assign lr_neg   = (LrW+2)'(0) - {2'b00, cfg.lr};

   always_comb begin
      if (sb_sum == '0) begin
         step_in = '0;
      end else if (sb_sum[SumW-1]) begin
         step_in = $signed(lr_neg[LrW+1:8]);
      end else begin
         step_in = $signed({2'b00, cfg.lr[LrW-1:8]});
      end
   end

   assign newp    = WideW'(p3_ff) - WideW'(step_ff) - WideW'(decay_ff);
   assign par_sat = sat_to_data(newp);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         p1_ff <= req_chan.param_in;
         m1_ff <= req_chan.momentum_in;
         g1_ff <= req_chan.gradient;
      end
      if (en2) begin
         p2_ff     <= p1_ff;
         sb_m_ff   <= sb_m_in;
         sb_g_ff   <= sb_g_in;
         mb_m_ff   <= mb_m_in;
         mb_g_ff   <= mb_g_in;
         dec_hi_ff <= dec_hi_in;
         dec_lo_ff <= dec_lo_in;
      end
      if (en3) begin
         p3_ff    <= p2_ff;
         step_ff  <= step_in;
         decay_ff <= decay_in;
         mom_ff   <= mom_sat.value;
         msat_ff  <= mom_sat.clip;
      end
      if (en4) begin
         po_ff <= par_sat.value;
         mo_ff <= mom_ff;
         so_ff <= par_sat.clip || msat_ff;
      end
   end

   assign rsp_chan.valid        = v4_ff;
   assign rsp_chan.param_out    = po_ff;
   assign rsp_chan.momentum_out = mo_ff;
   assign rsp_chan.saturated    = so_ff;
endmodule

>>> rtl/sign_momentum_optimizer_update_top.sv
// Top level of the sign-momentum (Lion-style) optimizer update block.
// Takes one element (parameter, momentum, gradient, Q8.24) per clock and
// returns one beat per element, in order. Throughput is one element per
// clock when the output side is not stalled, set by the four-stage
// pipeline (input, multipliers, sums, parameter subtract and saturation);
// backpressure stalls each full stage; bubbles are squeezed out. Registers
// sit at byte addresses 0 (learning rate), 4 (beta1), 8 (beta2) and 12
// (decay); the user must write them over the APB port only while no element
// is in flight, which the block does not enforce. The lr*decay product is
// registered, so let it update after a write before sending elements.
module sign_momentum_optimizer_update_top (
   input  logic                       clock,
   input  logic                       reset,
   smou_req_if.sink                   req_chan,
   smou_rsp_if.source                 rsp_chan,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [smou_pkg::AddrW-1:0] csr_paddr,
   input  logic [smou_pkg::CsrW-1:0]  csr_pwdata,
   output logic [smou_pkg::CsrW-1:0]  csr_prdata,
   output logic                       csr_pready
);
   import smou_pkg::*;

   cfg_type cfg;

   smou_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   smou_pipe u_pipe (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );
endmodule
